// File: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned PidWidth      = 16;
  localparam int unsigned BurstWidth    = 16;
  localparam int unsigned PrioWidth     = 8;
  localparam int unsigned OpWidth       = 2;
  localparam int unsigned CountOutWidth = 5;
  localparam int unsigned StatusWidth   = 2;

  localparam logic [OpWidth-1:0] OP_INSERT = 2'd0;
  localparam logic [OpWidth-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpWidth-1:0] OP_PEEK   = 2'd2;

  localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OpWidth-1:0]    opcode;
    logic [PidWidth-1:0]   item_pid;
    logic [BurstWidth-1:0] item_burst;
    logic [PrioWidth-1:0]  item_priority;
  } in_t;

  typedef struct packed {
    logic                     head_valid;
    logic [PidWidth-1:0]      head_pid;
    logic [BurstWidth-1:0]    head_burst;
    logic [PrioWidth-1:0]     head_priority;
    logic [CountOutWidth-1:0] entry_count;
    logic [StatusWidth-1:0]   status;
  } out_t;

  typedef struct packed {
    logic [PidWidth-1:0]   pid;
    logic [BurstWidth-1:0] burst;
    logic [PrioWidth-1:0]  prio;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic remove;
    rec_t rec;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occ,
  input  wire logic      prev_keep,
  input  wire rec_t      prev_rec,
  input  wire rec_t      next_rec,
  output rec_t           rec,
  output rec_t           rec_next,
  output logic           keep
);

  // A cell keeps its record on insert when it already sorts at or ahead of the new one.
  assign keep = occ && (rec.prio <= ctl.rec.prio);

  always_comb begin
    rec_next = rec;
    if (ctl.insert) begin
      if (keep) begin
        rec_next = rec;
      end else if (prev_keep) begin
        rec_next = ctl.rec;
      end else begin
        rec_next = prev_rec;
      end
    end else if (ctl.remove) begin
      rec_next = next_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// The result beat for an accepted item is registered and offered in the cycle after acceptance.
// One item per cycle while result beats are taken; every cell compares and shifts in parallel.
// An item is accepted only when the output register is empty or its beat leaves that cycle.
// Reset clears the entry count and the output valid flag; record contents are not cleared.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int unsigned CountWidth = $clog2(QUEUE_DEPTH + 1);

  logic [CountWidth-1:0] count;
  logic [CountWidth-1:0] count_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  do_insert;
  logic                  do_remove;
  logic [StatusWidth-1:0] status;
  cell_ctl_t             ctl;
  out_t                  result;
  logic [CountWidth+CountOutWidth-1:0] count_ext;

  rec_t        cell_rec  [QUEUE_DEPTH];
  rec_t        cell_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_keep;
  logic [QUEUE_DEPTH-1:0] cell_occ;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CountWidth'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  assign do_insert = accept && (in_data.opcode == OP_INSERT) && !full;
  assign do_remove = accept && (in_data.opcode == OP_REMOVE) && !empty;

  assign ctl.insert    = do_insert;
  assign ctl.remove    = do_remove;
  assign ctl.rec.pid   = in_data.item_pid;
  assign ctl.rec.burst = in_data.item_burst;
  assign ctl.rec.prio  = in_data.item_priority;

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CountWidth'(1);
    end else if (do_remove) begin
      count_next = count - CountWidth'(1);
    end
  end

  always_comb begin
    status = ST_OK;
    unique case (in_data.opcode) inside
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end
      end
      OP_REMOVE, OP_PEEK: begin
        if (empty) begin
          status = ST_EMPTY;
        end
      end
      default: begin
        if (empty) begin
          status = ST_EMPTY;
        end
      end
    endcase
  end

  generate
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      rec_t prev_rec;
      rec_t next_rec;
      logic prev_keep;

      assign cell_occ[i] = (count > CountWidth'(i));

      if (i == 0) begin : g_first
        assign prev_keep = 1'b1;
        assign prev_rec  = ctl.rec;
      end else begin : g_rest
        assign prev_keep = cell_keep[i-1];
        assign prev_rec  = cell_rec[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign next_rec = cell_rec[i];
      end else begin : g_inner
        assign next_rec = cell_rec[i+1];
      end

      spq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (cell_occ[i]),
        .prev_keep (prev_keep),
        .prev_rec  (prev_rec),
        .next_rec  (next_rec),
        .rec       (cell_rec[i]),
        .rec_next  (cell_next[i]),
        .keep      (cell_keep[i])
      );
    end
  endgenerate

  assign count_ext = {{CountOutWidth{1'b0}}, count_next};

  always_comb begin
    result.head_valid    = (count_next != '0);
    result.head_pid      = '0;
    result.head_burst    = '0;
    result.head_priority = '0;
    if (count_next != '0) begin
      result.head_pid      = cell_next[0].pid;
      result.head_burst    = cell_next[0].burst;
      result.head_priority = cell_next[0].prio;
    end
    result.entry_count = count_ext[CountOutWidth-1:0];
    result.status      = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned QDepth      = 16;
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReports  = 10;
  localparam logic [OpWidth-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t want;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  rec_t        sorted_recs[$];
  out_t        expected_heads[$];
  dir_row_t    dir_rows[$];
  out_t        head_want;
  int unsigned send_idle      = 0;
  int unsigned recv_stall     = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned ops_sent       = 0;
  int unsigned full_drops     = 0;
  int unsigned empty_reports  = 0;
  int unsigned peak_count     = 0;
  int unsigned cycle_count    = 0;

  sorted_priority_queue #(
    .QUEUE_DEPTH(QDepth)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_heads.size());
      $display("sorted_priority_queue: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic out_t make_res(logic valid, logic [PidWidth-1:0] pid,
                                    logic [BurstWidth-1:0] burst,
                                    logic [PrioWidth-1:0] prio,
                                    logic [CountOutWidth-1:0] cnt,
                                    logic [StatusWidth-1:0] st);
    out_t r;
    r.head_valid    = valid;
    r.head_pid      = pid;
    r.head_burst    = burst;
    r.head_priority = prio;
    r.entry_count   = cnt;
    r.status        = st;
    return r;
  endfunction

  function automatic void add_row(logic [OpWidth-1:0] op, logic [PidWidth-1:0] pid,
                                  logic [BurstWidth-1:0] burst,
                                  logic [PrioWidth-1:0] prio,
                                  logic typed, out_t want);
    dir_row_t row;
    row.item.opcode        = op;
    row.item.item_pid      = pid;
    row.item.item_burst    = burst;
    row.item.item_priority = prio;
    row.typed              = typed;
    row.want               = want;
    dir_rows.push_back(row);
  endfunction

  // Records of equal priority keep their arrival order: a new record goes
  // after every record whose priority is lower than or equal to its own.
  function automatic out_t apply_queue_op(in_t x);
    out_t r;
    rec_t rec;
    int   pos;
    r        = '0;
    r.status = ST_OK;
    case (x.opcode)
      OP_INSERT: begin
        if (sorted_recs.size() >= QDepth) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < sorted_recs.size() && sorted_recs[pos].prio <= x.item_priority)
            pos++;
          rec.pid   = x.item_pid;
          rec.burst = x.item_burst;
          rec.prio  = x.item_priority;
          sorted_recs.insert(pos, rec);
        end
      end
      OP_REMOVE: begin
        if (sorted_recs.size() == 0) r.status = ST_EMPTY;
        else void'(sorted_recs.pop_front());
      end
      default: begin
        if (sorted_recs.size() == 0) r.status = ST_EMPTY;
      end
    endcase
    if (sorted_recs.size() > 0) begin
      r.head_valid    = 1'b1;
      r.head_pid      = sorted_recs[0].pid;
      r.head_burst    = sorted_recs[0].burst;
      r.head_priority = sorted_recs[0].prio;
    end
    r.entry_count = CountOutWidth'(sorted_recs.size());
    if (r.status == ST_FULL) full_drops++;
    if (r.status == ST_EMPTY) empty_reports++;
    if (sorted_recs.size() > peak_count) peak_count = sorted_recs.size();
    return r;
  endfunction

  function automatic in_t random_op(int unsigned insert_pct);
    in_t         x;
    int unsigned roll;
    x.item_pid   = PidWidth'($urandom);
    x.item_burst = BurstWidth'($urandom);
    case ($urandom_range(3))
      0:       x.item_priority = PrioWidth'($urandom_range(3));
      1:       x.item_priority = $urandom_range(1) ? 8'hFF : 8'h00;
      default: x.item_priority = PrioWidth'($urandom);
    endcase
    roll = $urandom_range(99);
    if (roll < insert_pct) x.opcode = OP_INSERT;
    else if (roll < 88)    x.opcode = OP_REMOVE;
    else if (roll < 96)    x.opcode = OP_PEEK;
    else                   x.opcode = OP_UNUSED;
    return x;
  endfunction

  // Returns at the edge at which the beat is accepted.
  task automatic offer_op(in_t x);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
    ops_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_heads.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_heads.size() == 0) begin
        if (mismatch_count < MaxReports)
          $display("Result beat with nothing expected: %p", out_data);
        mismatch_count++;
      end else begin
        head_want = expected_heads.pop_front();
        results_seen++;
        if (out_data.head_valid    !== head_want.head_valid    ||
            out_data.head_pid      !== head_want.head_pid      ||
            out_data.head_burst    !== head_want.head_burst    ||
            out_data.head_priority !== head_want.head_priority ||
            out_data.entry_count   !== head_want.entry_count   ||
            out_data.status        !== head_want.status) begin
          if (mismatch_count < MaxReports)
            $display({"Result %0d differs: expected valid %b pid %h burst %h prio %h ",
                      "count %0d status %0d, got valid %b pid %h burst %h prio %h ",
                      "count %0d status %0d"},
                     results_seen, head_want.head_valid, head_want.head_pid,
                     head_want.head_burst, head_want.head_priority,
                     head_want.entry_count, head_want.status,
                     out_data.head_valid, out_data.head_pid, out_data.head_burst,
                     out_data.head_priority, out_data.entry_count, out_data.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned insert_pct;
    in_t         item;
    out_t        predicted;
    out_t        none_held;

    none_held = make_res(1'b0, '0, '0, '0, 5'd0, ST_EMPTY);
    add_row(OP_PEEK,   16'h0000, 16'h0000, 8'h00, 1'b1, none_held);
    add_row(OP_REMOVE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, none_held);
    add_row(OP_UNUSED, 16'h0000, 16'h0000, 8'h00, 1'b1, none_held);
    add_row(OP_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
            make_res(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 5'd1, ST_OK));
    add_row(OP_REMOVE, 16'h0000, 16'h0000, 8'h00, 1'b1,
            make_res(1'b0, '0, '0, '0, 5'd0, ST_OK));
    add_row(OP_INSERT, 16'h0000, 16'h0000, 8'h00, 1'b1,
            make_res(1'b1, 16'h0000, 16'h0000, 8'h00, 5'd1, ST_OK));
    for (int k = 1; k < QDepth; k++)
      add_row(OP_INSERT, 16'(k), 16'hA5A5 ^ 16'(k),
              (k % 3 == 0) ? 8'h00 : (k % 3 == 1) ? 8'hFF : 8'h80, 1'b0, '0);
    add_row(OP_INSERT, 16'h1234, 16'h5678, 8'h00, 1'b1,
            make_res(1'b1, 16'h0000, 16'h0000, 8'h00, 5'd16, ST_FULL));
    add_row(OP_UNUSED, 16'h0000, 16'h0000, 8'h00, 1'b0, '0);
    add_row(OP_REMOVE, 16'h0000, 16'h0000, 8'h00, 1'b0, '0);
    add_row(OP_PEEK,   16'h0000, 16'h0000, 8'h00, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      offer_op(dir_rows[i].item);
      predicted = apply_queue_op(dir_rows[i].item);
      expected_heads.push_back(dir_rows[i].typed ? dir_rows[i].want : predicted);
    end

    // Runs of insert-heavy and remove-heavy traffic carry the queue between
    // full and empty many times over.
    insert_pct = 70;
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 62; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 62; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      for (int n = 0; n < RandomItems / 4; n++) begin
        if (n % 32 == 0) insert_pct = $urandom_range(1) ? 70 : 20;
        item = random_op(insert_pct);
        offer_op(item);
        expected_heads.push_back(apply_queue_op(item));
      end
    end

    drain_results();
    repeat (5) @(posedge clk);

    $display("Sent %0d operation beats and checked %0d result beats over four pacing phases.",
             ops_sent, results_seen);
    $display("Saw %0d dropped inserts on a full queue, %0d empty reports, peak occupancy %0d.",
             full_drops, empty_reports, peak_count);
    if (mismatch_count == 0 && expected_heads.size() == 0) begin
      $display("sorted_priority_queue: match");
    end else begin
      $display("%0d mismatches counted.", mismatch_count);
      $display("sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/tb_sorted_priority_queue.sv
